// ===== hdl/cdc_pkg.sv =====
// shared widths, codes, types and calendar tables of the calendar date counter
`default_nettype none

package cdc_pkg;

   // field widths
   localparam int YEAR_W   = 14;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int OFFSET_W = 11;
   localparam int WDAY_W   = 3;
   localparam int ORD_W    = 9;

   // internal widths
   localparam int ACC_W  = OFFSET_W + 1;   // signed day accumulator
   localparam int CENT_W = 8;              // year / 100
   localparam int REM_W  = 7;              // year % 100
   localparam int SUM_W  = 15;             // weekday sum
   localparam int FOLD_W = 6;              // weekday sum after one base-8 fold

   // stream widths
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // year / 100 by reciprocal multiply, exact for 14-bit years
   localparam int DIV100_MUL   = 5243;
   localparam int DIV100_SHIFT = 19;
   localparam int MUL_W        = YEAR_W + 14;
   localparam int CENT_SCALE   = 100;

   localparam logic [REM_W-1:0]   REM_LAST      = REM_W'(CENT_SCALE - 1);
   localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
   localparam logic [3:0]         DAYS_PER_WEEK = 4'd7;

   // request operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_DIV,
      ST_LD_REM,
      ST_LD_DAY,
      ST_STEP_ADD,
      ST_FWD,
      ST_BWD,
      ST_BWD_ADD,
      ST_FIN,
      ST_ORD_INIT,
      ST_ORD,
      ST_WD_A,
      ST_WD_B,
      ST_WD_FOLD,
      ST_WD_MOD,
      ST_OUT
   } cdc_state_type;

   typedef struct packed {
      logic [MONTH_W-1:0]      month;
      logic [CENT_W-1:0]       cent;
      logic [REM_W-1:0]        rem;
      logic signed [ACC_W-1:0] opa;
      logic signed [ACC_W-1:0] opb;
      logic                    use_mlen;
      logic                    sub;
   } cdc_alu_req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sum;
      logic [DAY_W-1:0]        mlen;
      logic                    gt_mlen;
      logic                    lt_one;
   } cdc_alu_rsp_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2:                    len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // (13 * mm + 8) / 5 with january and february counted as months 13 and 14
   function automatic logic [5:0] wday_term(input logic [MONTH_W-1:0] m);
      logic [5:0] t;
      case (m)
         4'd1:    t = 6'd35;
         4'd2:    t = 6'd38;
         4'd3:    t = 6'd9;
         4'd4:    t = 6'd12;
         4'd5:    t = 6'd14;
         4'd6:    t = 6'd17;
         4'd7:    t = 6'd19;
         4'd8:    t = 6'd22;
         4'd9:    t = 6'd25;
         4'd10:   t = 6'd27;
         4'd11:   t = 6'd30;
         4'd12:   t = 6'd32;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/calendar_date_counter.sv =====
// top level of the gregorian calendar date counter
//
// request channel (req_): one request per item. req_tuser is the operation:
// load sets the date from the load fields (year clamped to 1..MAX_YEAR, month
// to 1..12, day to 1..length of that month); step moves the held date by the
// signed offset, saturated to +-MAX_OFFSET days.
// response channel (rsp_): exactly one response per request with the date
// after the request, its weekday (0 sunday), its day of year and a range error
// flag; on a step that would leave years 1..MAX_YEAR the date is kept and the
// flag is set.
// a request is worked on by one shared day unit under a sequencer, and req_tready
// is low meanwhile, so the next request is taken only once the last has left it.
// a load splits the year and clamps the day; a step adds the offset, walks forward
// a month at a time while the day overruns the month, then back (a step back and
// the add of the next month length). both then sum the day of year month by month
// and find the weekday; the month walk and that sum set how long a request takes.
// the response sits in an output register; a stalled receiver holds it there
// while the next request is taken and worked on, and that request waits at its
// end until the register is free.
// reset (synchronous, active high) sets the date to 0001-01-01 and drops
// rsp_tvalid.
`default_nettype none

module calendar_date_counter import cdc_pkg::*; #(
   parameter int MAX_OFFSET = 1023,
   parameter int MAX_YEAR   = 9999
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // offset[10:0], load_year[24:11], load_month[28:25], load_day[33:29], zeros
   input  wire [REQ_DATA_W-1:0]   req_tdata,
   // op[0]
   input  wire                    req_tuser,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // year[13:0], month[17:14], day[22:18], weekday[25:23], ordinal_day[34:26],
   // range_error[35], zeros
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // offset bounds as the 11-bit field and MAX_OFFSET allow
   localparam int OFF_POS_MAX = (1 << (OFFSET_W - 1)) - 1;
   localparam int OFF_NEG_MAX = 1 << (OFFSET_W - 1);
   localparam int POS_LIM     = (MAX_OFFSET < OFF_POS_MAX) ? MAX_OFFSET : OFF_POS_MAX;
   localparam int NEG_LIM     = (MAX_OFFSET < OFF_NEG_MAX) ? MAX_OFFSET : OFF_NEG_MAX;
   localparam logic signed [ACC_W-1:0] POS_LIM_S = ACC_W'(POS_LIM);
   localparam logic signed [ACC_W-1:0] NEG_LIM_S = ACC_W'(-NEG_LIM);
   localparam logic [YEAR_W-1:0] MAX_YEAR_V = YEAR_W'(MAX_YEAR);
   localparam logic [YEAR_W-1:0] YEAR_ONE   = YEAR_W'(1);
   localparam int PAD_W = RSP_DATA_W - (YEAR_W + MONTH_W + DAY_W + WDAY_W + ORD_W + 1);

   // request fields
   logic [OFFSET_W-1:0]     req_offset;
   logic [YEAR_W-1:0]       req_load_year;
   logic [MONTH_W-1:0]      req_load_month;
   logic [DAY_W-1:0]        req_load_day;
   logic signed [ACC_W-1:0] req_off_ext;

   assign req_offset     = req_tdata[OFFSET_W-1:0];
   assign req_load_year  = req_tdata[OFFSET_W +: YEAR_W];
   assign req_load_month = req_tdata[OFFSET_W+YEAR_W +: MONTH_W];
   assign req_load_day   = req_tdata[OFFSET_W+YEAR_W+MONTH_W +: DAY_W];
   assign req_off_ext    = $signed({req_offset[OFFSET_W-1], req_offset});

   cdc_state_type state_ff, state_in;

   // date being worked on
   logic [YEAR_W-1:0]       wy_ff, wy_in;
   logic [MONTH_W-1:0]      wm_ff, wm_in;
   logic signed [ACC_W-1:0] wd_ff, wd_in;
   logic [CENT_W-1:0]       wcent_ff, wcent_in;
   logic [REM_W-1:0]        wrem_ff, wrem_in;

   // held date, with its year split kept alongside
   logic [YEAR_W-1:0]       cy_ff, cy_in;
   logic [MONTH_W-1:0]      cm_ff, cm_in;
   logic [DAY_W-1:0]        cd_ff, cd_in;
   logic [CENT_W-1:0]       ccent_ff, ccent_in;
   logic [REM_W-1:0]        crem_ff, crem_in;

   logic signed [ACC_W-1:0] off_ff, off_in;
   logic                    err_ff, err_in;
   logic [ORD_W-1:0]        ord_ff, ord_in;
   logic [MONTH_W-1:0]      mi_ff, mi_in;
   logic [SUM_W-1:0]        wsum_ff, wsum_in;
   logic [FOLD_W-1:0]       fold_ff, fold_in;
   logic [WDAY_W-1:0]       wday_ff, wday_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   cdc_alu_req_type alu_req;
   cdc_alu_rsp_type alu_rsp;

   cdc_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // year split helpers
   logic [MUL_W-1:0]  div_prod;
   logic [YEAR_W-1:0] cent_x100;
   logic              early_month;
   logic [YEAR_W-1:0] yy;
   logic [CENT_W-1:0] cyy;
   logic [3:0]        fold_sum;

   assign div_prod    = MUL_W'(wy_ff) * MUL_W'(DIV100_MUL);
   assign cent_x100   = YEAR_W'(wy_ff - YEAR_W'(YEAR_W'(wcent_ff) * YEAR_W'(CENT_SCALE)));
   // january and february count to the year before
   assign early_month = wm_ff <= MONTH_FEB;
   assign yy          = early_month ? (wy_ff - YEAR_ONE) : wy_ff;
   assign cyy         = (early_month && (wrem_ff == '0)) ? (wcent_ff - CENT_W'(1)) : wcent_ff;
   assign fold_sum    = {1'b0, fold_ff[5:3]} + {1'b0, fold_ff[2:0]};

   always_comb begin
      state_in     = state_ff;
      wy_in        = wy_ff;
      wm_in        = wm_ff;
      wd_in        = wd_ff;
      wcent_in     = wcent_ff;
      wrem_in      = wrem_ff;
      cy_in        = cy_ff;
      cm_in        = cm_ff;
      cd_in        = cd_ff;
      ccent_in     = ccent_ff;
      crem_in      = crem_ff;
      off_in       = off_ff;
      err_in       = err_ff;
      ord_in       = ord_ff;
      mi_in        = mi_ff;
      wsum_in      = wsum_ff;
      fold_in      = fold_ff;
      wday_in      = wday_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;

      alu_req.month    = wm_ff;
      alu_req.cent     = wcent_ff;
      alu_req.rem      = wrem_ff;
      alu_req.opa      = wd_ff;
      alu_req.opb      = off_ff;
      alu_req.use_mlen = 1'b1;
      alu_req.sub      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               err_in = 1'b0;
               if (req_tuser == OP_LOAD) begin
                  if (req_load_year == '0) begin
                     wy_in = YEAR_ONE;
                  end else if (req_load_year > MAX_YEAR_V) begin
                     wy_in = MAX_YEAR_V;
                  end else begin
                     wy_in = req_load_year;
                  end
                  if (req_load_month == '0) begin
                     wm_in = MONTH_JAN;
                  end else if (req_load_month > MONTH_DEC) begin
                     wm_in = MONTH_DEC;
                  end else begin
                     wm_in = req_load_month;
                  end
                  wd_in    = $signed({{(ACC_W-DAY_W){1'b0}}, req_load_day});
                  state_in = ST_LD_DIV;
               end else begin
                  wy_in    = cy_ff;
                  wm_in    = cm_ff;
                  wd_in    = $signed({{(ACC_W-DAY_W){1'b0}}, cd_ff});
                  wcent_in = ccent_ff;
                  wrem_in  = crem_ff;
                  if (req_off_ext > POS_LIM_S) begin
                     off_in = POS_LIM_S;
                  end else if (req_off_ext < NEG_LIM_S) begin
                     off_in = NEG_LIM_S;
                  end else begin
                     off_in = req_off_ext;
                  end
                  state_in = ST_STEP_ADD;
               end
            end
         end

         ST_LD_DIV: begin
            wcent_in = div_prod[DIV100_SHIFT +: CENT_W];
            state_in = ST_LD_REM;
         end

         ST_LD_REM: begin
            wrem_in  = cent_x100[REM_W-1:0];
            state_in = ST_LD_DAY;
         end

         ST_LD_DAY: begin
            // clamp the day to the loaded month
            if (alu_rsp.lt_one) begin
               wd_in = ACC_W'(1);
            end else if (alu_rsp.gt_mlen) begin
               wd_in = $signed({{(ACC_W-DAY_W){1'b0}}, alu_rsp.mlen});
            end
            state_in = ST_FIN;
         end

         ST_STEP_ADD: begin
            alu_req.use_mlen = 1'b0;
            wd_in            = alu_rsp.sum;
            state_in         = ST_FWD;
         end

         ST_FWD: begin
            // one month forward per cycle while the day overruns the month
            alu_req.sub = 1'b1;
            if (alu_rsp.gt_mlen) begin
               if (wm_ff == MONTH_DEC) begin
                  if (wy_ff == MAX_YEAR_V) begin
                     err_in   = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     wd_in = alu_rsp.sum;
                     wm_in = MONTH_JAN;
                     wy_in = wy_ff + YEAR_ONE;
                     if (wrem_ff == REM_LAST) begin
                        wrem_in  = '0;
                        wcent_in = wcent_ff + CENT_W'(1);
                     end else begin
                        wrem_in = wrem_ff + REM_W'(1);
                     end
                  end
               end else begin
                  wd_in = alu_rsp.sum;
                  wm_in = wm_ff + MONTH_W'(1);
               end
            end else begin
               state_in = ST_BWD;
            end
         end

         ST_BWD: begin
            // back one month; its length is added in the next cycle
            if (alu_rsp.lt_one) begin
               if (wm_ff == MONTH_JAN) begin
                  if (wy_ff == YEAR_ONE) begin
                     err_in   = 1'b1;
                     state_in = ST_FIN;
                  end else begin
                     wm_in = MONTH_DEC;
                     wy_in = wy_ff - YEAR_ONE;
                     if (wrem_ff == '0) begin
                        wrem_in  = REM_LAST;
                        wcent_in = wcent_ff - CENT_W'(1);
                     end else begin
                        wrem_in = wrem_ff - REM_W'(1);
                     end
                     state_in = ST_BWD_ADD;
                  end
               end else begin
                  wm_in    = wm_ff - MONTH_W'(1);
                  state_in = ST_BWD_ADD;
               end
            end else begin
               state_in = ST_FIN;
            end
         end

         ST_BWD_ADD: begin
            wd_in    = alu_rsp.sum;
            state_in = ST_BWD;
         end

         ST_FIN: begin
            if (err_ff) begin
               // out of range: fall back to the held date
               wy_in    = cy_ff;
               wm_in    = cm_ff;
               wd_in    = $signed({{(ACC_W-DAY_W){1'b0}}, cd_ff});
               wcent_in = ccent_ff;
               wrem_in  = crem_ff;
            end else begin
               cy_in    = wy_ff;
               cm_in    = wm_ff;
               cd_in    = wd_ff[DAY_W-1:0];
               ccent_in = wcent_ff;
               crem_in  = wrem_ff;
            end
            state_in = ST_ORD_INIT;
         end

         ST_ORD_INIT: begin
            ord_in   = wd_ff[ORD_W-1:0];
            mi_in    = MONTH_JAN;
            state_in = ST_ORD;
         end

         ST_ORD: begin
            // day of year: add the length of each month before this one
            alu_req.month = mi_ff;
            alu_req.opa   = $signed({{(ACC_W-ORD_W){1'b0}}, ord_ff});
            if (mi_ff < wm_ff) begin
               ord_in = alu_rsp.sum[ORD_W-1:0];
               mi_in  = mi_ff + MONTH_W'(1);
            end else begin
               state_in = ST_WD_A;
            end
         end

         ST_WD_A: begin
            wsum_in  = SUM_W'(yy) + SUM_W'(yy >> 2) + SUM_W'(cyy >> 2);
            state_in = ST_WD_B;
         end

         ST_WD_B: begin
            wsum_in  = wsum_ff - SUM_W'(cyy) + SUM_W'(wday_term(wm_ff)) +
                       SUM_W'(wd_ff[DAY_W-1:0]);
            state_in = ST_WD_FOLD;
         end

         ST_WD_FOLD: begin
            // 8 is 1 mod 7, so the octal digits sum to the same residue
            fold_in  = FOLD_W'(wsum_ff[2:0]) + FOLD_W'(wsum_ff[5:3]) +
                       FOLD_W'(wsum_ff[8:6]) + FOLD_W'(wsum_ff[11:9]) +
                       FOLD_W'(wsum_ff[14:12]);
            state_in = ST_WD_MOD;
         end

         ST_WD_MOD: begin
            if (fold_sum >= DAYS_PER_WEEK) begin
               wday_in = WDAY_W'(fold_sum - DAYS_PER_WEEK);
            end else begin
               wday_in = fold_sum[WDAY_W-1:0];
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {{PAD_W{1'b0}}, err_ff, ord_ff, wday_ff,
                               wd_ff[DAY_W-1:0], wm_ff, wy_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cy_ff        <= YEAR_ONE;
         cm_ff        <= MONTH_JAN;
         cd_ff        <= DAY_W'(1);
         ccent_ff     <= '0;
         crem_ff      <= REM_W'(1);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cy_ff        <= cy_in;
         cm_ff        <= cm_in;
         cd_ff        <= cd_in;
         ccent_ff     <= ccent_in;
         crem_ff      <= crem_in;
      end
   end

   always_ff @(posedge clock) begin
      wy_ff       <= wy_in;
      wm_ff       <= wm_in;
      wd_ff       <= wd_in;
      wcent_ff    <= wcent_in;
      wrem_ff     <= wrem_in;
      off_ff      <= off_in;
      err_ff      <= err_in;
      ord_ff      <= ord_in;
      mi_ff       <= mi_in;
      wsum_ff     <= wsum_in;
      fold_ff     <= fold_in;
      wday_ff     <= wday_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/cdc_alu.sv =====
// shared day unit: month length with leap rule, day add or subtract, compares
`default_nettype none

module cdc_alu import cdc_pkg::*; (
   input  cdc_alu_req_type alu_req,
   output cdc_alu_rsp_type alu_rsp
);

   logic                    leap;
   logic [DAY_W-1:0]        mlen;
   logic signed [ACC_W-1:0] mlen_ext;
   logic signed [ACC_W-1:0] opb_sel;

   // divisible by 4, and not by 100 unless by 400
   assign leap = (alu_req.rem[1:0] == 2'd0) &&
                 ((alu_req.rem != '0) || (alu_req.cent[1:0] == 2'd0));

   assign mlen     = month_days(alu_req.month, leap);
   assign mlen_ext = $signed({{(ACC_W-DAY_W){1'b0}}, mlen});
   assign opb_sel  = alu_req.use_mlen ? mlen_ext : alu_req.opb;

   assign alu_rsp.sum     = alu_req.sub ? (alu_req.opa - opb_sel) : (alu_req.opa + opb_sel);
   assign alu_rsp.mlen    = mlen;
   assign alu_rsp.gt_mlen = alu_req.opa > mlen_ext;
   assign alu_rsp.lt_one  = alu_req.opa[ACC_W-1] || (alu_req.opa == '0);

endmodule

`default_nettype wire

// ===== hdl/cdc_chk.sv =====
// port-level checks of the calendar date counter, bound to the top level
`default_nettype none

module cdc_chk import cdc_pkg::*; (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_tvalid,
   input wire                   req_tready,
   input wire                   rsp_tvalid,
   input wire                   rsp_tready,
   input wire [RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // the block is not ready in the cycle after it takes a request
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken on consecutive cycles");

   // reset leaves no response pending and the block ready
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("bad state after reset");

   // a request taken leaves no new response in the very next cycle
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response appeared one cycle after request");

endmodule

bind calendar_date_counter cdc_chk u_cdc_chk (.*);

`default_nettype wire
